>>> sv/rbsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsw_pkg: shared types and constants
// Item layouts, phase encoding and helper functions for the segment writer.
// ----------------------------------------------------------------------------
package rbsw_pkg;

   localparam int unsigned WORD_BYTES_DEF   = 8;
   localparam int unsigned WINDOW_BYTES_DEF = 65536;
   localparam int unsigned SESSION_BITS_DEF = 14;
   localparam logic [31:0] MEM_BASE         = 32'h4000_0000;
   localparam int unsigned QUEUE_DEPTH      = 4;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_FIRST   = 3'd1,
      PH_ALIGNED = 3'd3,
      PH_REALIGN = 3'd4
   } phase_type;

   typedef enum logic {
      KIND_CMD  = 1'b0,
      KIND_DATA = 1'b1
   } kind_type;

   typedef struct packed {
      logic        command;
      logic        drop_segment;
      logic [13:0] session_id;
      logic [15:0] buffer_offset;
      logic [15:0] segment_length;
      logic [63:0] in_data;
      logic [7:0]  in_keep;
      logic        in_last;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] write_address;
      logic [15:0] write_length;
      logic [63:0] out_data;
      logic [7:0]  out_keep;
      logic        out_last;
   } rsp_type;

   function automatic logic [7:0] byte_mask(input logic [16:0] n);
      logic [7:0] m;
      m = 8'hFF;
      if (n < 17'd8) begin
         m = 8'((9'd1 << n[2:0]) - 9'd1);
      end
      return m;
   endfunction

   function automatic logic [3:0] keep_count(input logic [7:0] keep);
      logic [3:0] c;
      logic       run;
      c   = 4'd0;
      run = 1'b1;
      for (int i = 0; i < 8; i++) begin
         run = run & keep[i];
         if (run) begin
            c = c + 4'd1;
         end
      end
      return c;
   endfunction

   function automatic logic [63:0] shift_down(input logic [63:0] w, input logic [2:0] s);
      return w >> {s, 3'b000};
   endfunction

   function automatic logic [63:0] join_words(input logic [63:0] held, input logic [63:0] fresh,
                                              input logic [2:0] s);
      logic [63:0] r;
      r = fresh;
      if (s != 3'd0) begin
         r = (held >> {s, 3'b000}) | (fresh << (7'd64 - {1'b0, s, 3'b000}));
      end
      return r;
   endfunction

   function automatic rsp_type make_cmd(input logic [31:0] a, input logic [15:0] l);
      rsp_type r;
      r               = '0;
      r.result_kind   = KIND_CMD;
      r.write_address = a;
      r.write_length  = l;
      return r;
   endfunction

   function automatic rsp_type make_data(input logic [63:0] d, input logic [7:0] k,
                                         input logic lst);
      rsp_type r;
      r             = '0;
      r.result_kind = KIND_DATA;
      r.out_data    = d;
      r.out_keep    = k;
      r.out_last    = lst;
      return r;
   endfunction

   // classified work handed from front to back
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
      rsp_type    r2;
   } batch_type;

endpackage

>>> sv/rbsw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsw_req_if / rbsw_rsp_if: valid/ready channels
// Input item channel and result item channel.
// ----------------------------------------------------------------------------
interface rbsw_req_if import rbsw_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rbsw_rsp_if import rbsw_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/rbsw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsw_front: segment sequencer
// Accepts items, tracks segment phase, and forms up to three result items.
// ----------------------------------------------------------------------------
module rbsw_front import rbsw_pkg::*; #(
   parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int unsigned SESSION_BITS = SESSION_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   input  req_type   item,
   output logic      item_ready,
   output logic      batch_valid,
   output batch_type batch,
   input  logic      batch_ready
);
   localparam int unsigned OFF_BITS = $clog2(WINDOW_BYTES);

   phase_type   phase_ff, phase_in;
   logic        dropping_ff, dropping_in;
   logic        split_ff, split_in;
   logic [31:0] start_ff, start_in;
   logic [16:0] left_ff, left_in;
   logic [15:0] second_ff, second_in;
   logic [3:0]  shift_ff, shift_in;
   logic [2:0]  residue_ff, residue_in;
   logic [63:0] held_ff, held_in;

   logic        fire;
   logic [16:0] off, len, first, kc, thr;
   logic [31:0] base;
   logic [16:0] rleft;

   assign item_ready  = batch_ready;
   assign fire        = item_valid & item_ready;
   assign batch_valid = fire && (batch.count != 2'd0);

   always_comb begin
      phase_in   = phase_ff;
      dropping_in = dropping_ff;
      split_in   = split_ff;
      start_in   = start_ff;
      left_in    = left_ff;
      second_in  = second_ff;
      shift_in   = shift_ff;
      residue_in = residue_ff;
      held_in    = held_ff;
      batch      = '0;
      off   = 17'(item.buffer_offset[OFF_BITS-1:0]);
      len   = 17'(item.segment_length);
      base  = MEM_BASE + (32'(item.session_id[SESSION_BITS-1:0]) << OFF_BITS);
      first = len;
      kc    = 17'(keep_count(item.in_keep));
      thr   = 17'(residue_ff) + 17'(shift_ff);
      rleft = (left_ff > 17'd8) ? left_ff - 17'd8 : 17'd0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!item.command) begin
               dropping_in = item.drop_segment;
               split_in    = 1'b0;
               phase_in    = PH_FIRST;
               if (!item.drop_segment) begin
                  start_in = base;
                  if (off + len > 17'(WINDOW_BYTES)) begin
                     first     = 17'(WINDOW_BYTES) - off;
                     second_in = 16'(len - first);
                     split_in  = 1'b1;
                  end else begin
                     second_in = '0;
                  end
                  left_in     = first;
                  batch.count = 2'd1;
                  batch.r0    = make_cmd(base + 32'(off), first[15:0]);
               end
            end
         end
         PH_FIRST: begin
            if (item.command) begin
               if (dropping_ff) begin
                  if (item.in_last) begin
                     phase_in    = PH_IDLE;
                     dropping_in = 1'b0;
                  end
               end else if (left_ff > 17'd8) begin
                  left_in     = left_ff - 17'd8;
                  batch.count = 2'd1;
                  batch.r0    = make_data(item.in_data, item.in_keep, item.in_last);
               end else if (!split_ff) begin
                  left_in     = '0;
                  phase_in    = PH_IDLE;
                  batch.count = 2'd1;
                  batch.r0    = make_data(item.in_data, item.in_keep, item.in_last);
               end else begin
                  batch.count = 2'd2;
                  batch.r0    = make_data(item.in_data, byte_mask(left_ff), 1'b1);
                  batch.r1    = make_cmd(start_ff, second_ff);
                  split_in    = 1'b0;
                  shift_in    = left_ff[3:0];
                  held_in     = item.in_data;
                  left_in     = 17'(second_ff);
                  if (left_ff >= 17'd8) begin
                     phase_in = PH_ALIGNED;
                  end else begin
                     residue_in = (kc > left_ff) ? 3'(kc - left_ff) : 3'd0;
                     if (17'(second_ff) > 17'(residue_in)) begin
                        phase_in = PH_REALIGN;
                     end else begin
                        batch.count = 2'd3;
                        batch.r2    = make_data(shift_down(item.in_data, left_ff[2:0]),
                                                byte_mask(17'(second_ff)), 1'b1);
                        left_in     = '0;
                        phase_in    = PH_IDLE;
                     end
                  end
               end
            end
         end
         PH_ALIGNED: begin
            if (item.command) begin
               batch.count = 2'd1;
               batch.r0    = make_data(item.in_data, item.in_keep, item.in_last);
               if (item.in_last) phase_in = PH_IDLE;
            end
         end
         PH_REALIGN: begin
            if (item.command) begin
               held_in  = item.in_data;
               batch.r0 = make_data(join_words(held_ff, item.in_data, shift_ff[2:0]),
                                    8'hFF, 1'b0);
               batch.count = 2'd1;
               if (item.in_last) begin
                  phase_in = PH_IDLE;
                  left_in  = '0;
                  if (left_ff > thr) begin
                     batch.count = 2'd2;
                     batch.r1    = make_data(shift_down(item.in_data, shift_ff[2:0]),
                                             byte_mask(rleft), 1'b1);
                  end else begin
                     batch.r0.out_keep = byte_mask(left_ff);
                     batch.r0.out_last = 1'b1;
                  end
               end else begin
                  left_in = rleft;
               end
            end
         end
         default: begin
            if (item.command) phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         dropping_ff <= 1'b0;
         split_ff    <= 1'b0;
         start_ff    <= '0;
         left_ff     <= '0;
         second_ff   <= '0;
         shift_ff    <= '0;
         residue_ff  <= '0;
         held_ff     <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         dropping_ff <= dropping_in;
         split_ff    <= split_in;
         start_ff    <= start_in;
         left_ff     <= left_in;
         second_ff   <= second_in;
         shift_ff    <= shift_in;
         residue_ff  <= residue_in;
         held_ff     <= held_in;
      end
   end
endmodule

>>> sv/rbsw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsw_back: batch queue and result serializer
// Small queue of batches; each batch is sent out one result item per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module rbsw_back import rbsw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      batch_valid,
   input  batch_type batch,
   output logic      batch_ready,
   output logic      out_valid,
   output rsp_type   out_item,
   input  logic      out_ready
);
   localparam int unsigned AW = $clog2(QUEUE_DEPTH);

   batch_type       q_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic [1:0]      sub_ff, sub_in;
   logic            push, pop, take;
   batch_type       head;

   assign head        = q_ff[rd_ff];
   assign batch_ready = (cnt_ff != (AW+1)'(QUEUE_DEPTH));
   assign push        = batch_valid & batch_ready;
   assign out_valid   = (cnt_ff != '0);
   assign take        = out_valid & out_ready;
   assign pop         = take && (sub_ff == head.count - 2'd1);

   always_comb begin
      unique case (sub_ff)
         2'd0:    out_item = head.r0;
         2'd1:    out_item = head.r1;
         default: out_item = head.r2;
      endcase
      wr_in  = push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      sub_in = pop ? 2'd0 : (take ? sub_ff + 2'd1 : sub_ff);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= batch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         sub_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
      end
   end
endmodule

>>> sv/ring_buffer_segment_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_segment_writer_unit: per-session window write command generator
// Turns segment metadata plus data words into write commands and data items.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries metadata items (command = 0) and data word items (command = 1).
//   rsp_ carries write commands (result_kind = 0) and data words (result_kind = 1).
//   A metadata item yields one command unless dropped; a data word yields one data
//   item (none while dropping, two at a realigned end), or at a window split the
//   closing word, second command and possibly a residue word: up to three results.
//   The front sequencer takes one item per cycle while the queue has room and writes
//   its results as one batch into a four-entry queue; results appear in the cycle
//   after acceptance at the earliest. The back end sends one result per cycle while
//   rsp_ready is high, so items flow at one per cycle unless one yields several.
//   Reset (synchronous) returns to waiting for metadata and empties the queue.
//   When the receiver stalls, the queue fills and req_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module ring_buffer_segment_writer_unit import rbsw_pkg::*; #(
   parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF,
   parameter int unsigned SESSION_BITS = SESSION_BITS_DEF
) (
   input logic            clock,
   input logic            reset,
   rbsw_req_if.sink       req,
   rbsw_rsp_if.source     rsp
);
   logic      b_valid, b_ready;
   batch_type b;

   rbsw_front #(.WINDOW_BYTES(WINDOW_BYTES), .SESSION_BITS(SESSION_BITS)) u_front (
      .clock(clock), .reset(reset),
      .item_valid(req.valid), .item(req.payload), .item_ready(req.ready),
      .batch_valid(b_valid), .batch(b), .batch_ready(b_ready)
   );

   rbsw_back u_back (
      .clock(clock), .reset(reset),
      .batch_valid(b_valid), .batch(b), .batch_ready(b_ready),
      .out_valid(rsp.valid), .out_item(rsp.payload), .out_ready(rsp.ready)
   );
endmodule

>>> sv/rbsw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsw_checker: port-level checks
// Observes the top level's channels.
// ----------------------------------------------------------------------------
module rbsw_checker import rbsw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_cmd_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_CMD |->
         rsp_payload.out_keep == 8'd0 && !rsp_payload.out_last)
      else $error("command carries data fields");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_kind == KIND_DATA |->
         rsp_payload.write_length == 16'd0)
      else $error("data item carries length");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // input only stalls while results are waiting
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");
endmodule

bind ring_buffer_segment_writer_unit rbsw_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
